### rtl/p2fl_pkg.sv
// ----------------------------------------------------------------------------
// p2fl_pkg
// shared types, constants and helpers for the power-of-two free-list allocator
// ----------------------------------------------------------------------------
package p2fl_pkg;

    localparam int NUM_CLASSES   = 17;
    localparam int ADDR_BITS     = 20;

    // fixed field widths
    localparam int CMD_BITS      = 1;
    localparam int COUNT_BITS    = 17;
    localparam int FADDR_BITS    = 20;
    localparam int SCLASS_BITS   = 5;
    localparam int STATUS_BITS   = 2;

    // link: valid bit above the address
    localparam int LINK_BITS     = ADDR_BITS + 1;
    // a first word holds either a link or a count
    localparam int WORD_BITS     = (LINK_BITS > COUNT_BITS) ? LINK_BITS : COUNT_BITS;
    localparam int CLS_BITS      = $clog2(WORD_BITS + 1);
    localparam int HEAD_IDX_BITS = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    // block size 3*2^c+1 for c below NUM_CLASSES
    localparam int SIZE_BITS     = NUM_CLASSES + 2;
    localparam int SUM_BITS      = ((SIZE_BITS > LINK_BITS) ? SIZE_BITS : LINK_BITS) + 1;

    localparam logic [CMD_BITS-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_BITS-1:0] CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_TOO_LARGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WB
    } state_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [COUNT_BITS-1:0] tri_count;
        logic [FADDR_BITS-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [FADDR_BITS-1:0]  block_addr;
        logic [SCLASS_BITS-1:0] size_class;
        logic [STATUS_BITS-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic                     en;
        logic [HEAD_IDX_BITS-1:0] idx;
        logic [WORD_BITS-1:0]     data;
    } head_wr_t;

    // ceil(log2(n)), zero for n of 0 or 1
    function automatic logic [CLS_BITS-1:0] ceil_log2(input logic [WORD_BITS-1:0] n);
        logic [WORD_BITS-1:0] m;
        logic [CLS_BITS-1:0]  r;
        m = n - WORD_BITS'(1);
        r = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (m[i])
            begin
                r = CLS_BITS'(i + 1);
            end
        end
        if (n <= WORD_BITS'(1))
        begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic class_too_large(input logic [CLS_BITS-1:0] cls);
        return 8'(cls) >= 8'(NUM_CLASSES);
    endfunction

    function automatic logic [HEAD_IDX_BITS-1:0] class_idx(input logic [CLS_BITS-1:0] cls);
        logic [7:0] t;
        t = 8'(cls);
        return t[HEAD_IDX_BITS-1:0];
    endfunction

    function automatic logic [FADDR_BITS-1:0] to_field_addr(input logic [ADDR_BITS-1:0] a);
        logic [63:0] w;
        w = 64'(a);
        return w[FADDR_BITS-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] from_field_addr(input logic [FADDR_BITS-1:0] f);
        logic [63:0] w;
        w = 64'(f);
        return w[ADDR_BITS-1:0];
    endfunction

endpackage

### rtl/p2fl_word_ram.sv
// ----------------------------------------------------------------------------
// p2fl_word_ram
// generic single-clock ram, one write and one registered read port
// ----------------------------------------------------------------------------
module p2fl_word_ram #(
    parameter int AW = 20,
    parameter int DW = 21
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/p2fl_head_file.sv
// ----------------------------------------------------------------------------
// p2fl_head_file
// per-class free-list heads, cleared to the null link on reset
// ----------------------------------------------------------------------------
module p2fl_head_file
    import p2fl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  head_wr_t                 wr,
    input  logic [HEAD_IDX_BITS-1:0] rd_idx,
    output logic [WORD_BITS-1:0]     rd_data
);

    logic [WORD_BITS-1:0] heads_reg [NUM_CLASSES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            heads_reg[wr.idx] <= wr.data;
        end
    end

    // out-of-range index reads as null
    always_comb
    begin
        rd_data = '0;
        if (32'(rd_idx) < NUM_CLASSES)
        begin
            rd_data = heads_reg[rd_idx];
        end
    end

endmodule

### rtl/pow2_class_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// pow2_class_free_list_allocator_unit
// segregated power-of-two free-list allocator for triangle storage
// ----------------------------------------------------------------------------
//
//  channel | valid     | ready     | word
//  --------+-----------+-----------+-----------------------------------------
//  request | req_valid | req_ready | req : cmd, tri_count, free_addr
//  result  | rsp_valid | rsp_ready | rsp : block_addr, size_class, status
//
//  pop from a list or free: accept, head lookup and first-word read,
//  write-back; bump carve or rejected request: accept, head lookup
//  the first-word ram read is registered and sits between the head lookup
//  and the write-back; one request is in flight at a time
//  reset clears the class heads and the bump pointer at once; the first-word
//  ram has no reset and needs no clearing pass
//  a finished word sits in the output register; a new request is taken while
//  it waits, and that request holds at its final step until the slot frees
//
module pow2_class_free_list_allocator_unit
    import p2fl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // heap size as a bump-pointer value
    localparam logic [LINK_BITS-1:0] HEAP_WORDS = {1'b1, {ADDR_BITS{1'b0}}};

    state_t state_reg, state_next;

    // captured request
    logic [CMD_BITS-1:0]   cmd_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [ADDR_BITS-1:0]  faddr_reg;
    logic [CLS_BITS-1:0]   acls_reg;

    // bump pointer, may reach the full heap size
    logic [LINK_BITS-1:0]  heap_top_reg, heap_top_next;

    logic                  out_valid_reg, out_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  accept;
    logic                  slot_free;
    logic                  finish;

    // head file
    head_wr_t              head_wr;
    logic [HEAD_IDX_BITS-1:0] head_rd_idx;
    logic [WORD_BITS-1:0]  head_rd;

    // first-word ram
    logic                  ram_wr_en;
    logic [ADDR_BITS-1:0]  ram_wr_addr;
    logic [WORD_BITS-1:0]  ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_BITS-1:0]  ram_rd_addr;
    logic [WORD_BITS-1:0]  ram_rd_data;

    // datapath terms
    logic                  is_free;
    logic                  alloc_big;
    logic                  head_valid;
    logic [ADDR_BITS-1:0]  head_addr;
    logic [CLS_BITS-1:0]   fcls;
    logic                  free_big;
    logic [SIZE_BITS-1:0]  blk_size;
    logic [SUM_BITS-1:0]   bump_sum;
    logic                  bump_fits;
    logic                  need_read;

    assign accept    = req_valid && req_ready;
    assign slot_free = !out_valid_reg || rsp_ready;

    assign is_free    = (cmd_reg == CMD_FREE);
    assign alloc_big  = class_too_large(acls_reg);
    assign head_valid = head_rd[ADDR_BITS];
    assign head_addr  = head_rd[ADDR_BITS-1:0];

    // class of the word read back on a free
    assign fcls     = ceil_log2(ram_rd_data);
    assign free_big = class_too_large(fcls);

    // bump carve: 3*2^c+1 words must still fit
    assign blk_size  = (SIZE_BITS'(3) << acls_reg) + SIZE_BITS'(1);
    assign bump_sum  = SUM_BITS'(heap_top_reg) + SUM_BITS'(blk_size);
    assign bump_fits = (bump_sum <= SUM_BITS'(HEAP_WORDS));

    // a free, or a pop from a non-empty list, goes through the ram read
    assign need_read = is_free || (!alloc_big && head_valid);

    // head lookup: allocate class, or on write-back of a free the stored class
    assign head_rd_idx = ((state_reg == ST_WB) && is_free) ? class_idx(fcls)
                                                            : class_idx(acls_reg);

    p2fl_head_file u_heads (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (head_wr),
        .rd_idx  (head_rd_idx),
        .rd_data (head_rd)
    );

    p2fl_word_ram #(
        .AW (ADDR_BITS),
        .DW (WORD_BITS)
    ) u_first_word (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (need_read)
                begin
                    state_next = ST_WB;
                end
                else if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WB:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        finish        = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = faddr_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = faddr_reg;
        ram_wr_data   = WORD_BITS'(count_reg);
        head_wr.en    = 1'b0;
        head_wr.idx   = class_idx(acls_reg);
        head_wr.data  = ram_rd_data;
        heap_top_next = heap_top_reg;
        rsp_next      = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOOK:
            begin
                if (need_read)
                begin
                    // fetch the first word of the list head or of the freed block
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = is_free ? faddr_reg : head_addr;
                end
                else if (slot_free)
                begin
                    finish              = 1'b1;
                    rsp_next.block_addr = '0;
                    rsp_next.size_class = acls_reg[SCLASS_BITS-1:0];
                    if (alloc_big)
                    begin
                        rsp_next.status = STATUS_TOO_LARGE;
                    end
                    else if (bump_fits)
                    begin
                        // carve a fresh block and stamp its count
                        rsp_next.block_addr = to_field_addr(heap_top_reg[ADDR_BITS-1:0]);
                        rsp_next.status     = STATUS_OK;
                        heap_top_next       = bump_sum[LINK_BITS-1:0];
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = heap_top_reg[ADDR_BITS-1:0];
                        ram_wr_data         = WORD_BITS'(count_reg);
                    end
                    else
                    begin
                        rsp_next.status = STATUS_EXHAUSTED;
                    end
                end
            end
            ST_WB:
            begin
                if (slot_free)
                begin
                    finish = 1'b1;
                    if (is_free)
                    begin
                        rsp_next.size_class = fcls[SCLASS_BITS-1:0];
                        if (free_big)
                        begin
                            rsp_next.block_addr = '0;
                            rsp_next.status     = STATUS_TOO_LARGE;
                        end
                        else
                        begin
                            // push: block links to old head, head points at block
                            rsp_next.block_addr = to_field_addr(faddr_reg);
                            rsp_next.status     = STATUS_OK;
                            ram_wr_en           = 1'b1;
                            ram_wr_addr         = faddr_reg;
                            ram_wr_data         = head_rd;
                            head_wr.en          = 1'b1;
                            head_wr.idx         = class_idx(fcls);
                            head_wr.data        = WORD_BITS'({1'b1, faddr_reg});
                        end
                    end
                    else
                    begin
                        // pop: head takes the stored link, block takes its count
                        rsp_next.block_addr = to_field_addr(head_addr);
                        rsp_next.size_class = acls_reg[SCLASS_BITS-1:0];
                        rsp_next.status     = STATUS_OK;
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = head_addr;
                        ram_wr_data         = WORD_BITS'(count_reg);
                        head_wr.en          = 1'b1;
                        head_wr.idx         = class_idx(acls_reg);
                        head_wr.data        = ram_rd_data;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = finish ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            heap_top_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_top_reg  <= heap_top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.cmd;
            count_reg <= req.tri_count;
            faddr_reg <= from_field_addr(req.free_addr);
            acls_reg  <= ceil_log2(WORD_BITS'(req.tri_count));
        end
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### tb/pow2_class_free_list_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow2_class_free_list_allocator_unit_tb
// self-checking bench for the power-of-two free-list allocator: allocate and
// free traffic against an in-bench heap model, with random gaps on both
// channels and a run that fills the heap to exhaustion
// ----------------------------------------------------------------------------
module pow2_class_free_list_allocator_unit_tb;
    import p2fl_pkg::*;

    // heap size in words
    localparam longint unsigned HEAP_WORDS = 64'd1 << ADDR_BITS;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // heap model: list heads, first word of every block written so far, bump pointer
    logic [WORD_BITS-1:0] list_head [NUM_CLASSES];
    logic [WORD_BITS-1:0] first_word_of [int unsigned];
    longint unsigned      heap_top_words;

    // blocks handed out and not yet freed, and every block address ever carved
    logic [ADDR_BITS-1:0] live_blocks [$];
    logic [ADDR_BITS-1:0] carved_blocks [$];

    // results still owed by the block, oldest first
    rsp_t expected_blocks [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;

    pow2_class_free_list_allocator_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ceil(log2(n)), a count of 0 or 1 lands in class 0
    function automatic int class_of(input longint unsigned n);
        int c;
        c = 0;
        while (c < 63 && (64'd1 << c) < n)
        begin
            c++;
        end
        return c;
    endfunction

    // apply one accepted request word to the heap model and return its result
    function automatic rsp_t allocate_or_free(input req_t w);
        rsp_t                 r;
        int                   c;
        logic [ADDR_BITS-1:0] a;
        longint unsigned      span;
        longint unsigned      stored;
        r = '0;
        r.status = STATUS_OK;
        if (w.cmd == CMD_ALLOC)
        begin
            c = class_of(w.tri_count);
            if (c >= NUM_CLASSES)
            begin
                // count beyond the largest class: nothing changes
                r.status = STATUS_TOO_LARGE;
            end
            else if (list_head[c][ADDR_BITS])
            begin
                // pop the head, its first word becomes the new head
                a = list_head[c][ADDR_BITS-1:0];
                r.block_addr = a;
                list_head[c] = first_word_of[a];
                first_word_of[a] = WORD_BITS'(w.tri_count);
            end
            else
            begin
                // empty list: carve 3*2^c+1 words from the bump pointer
                span = 3 * (64'd1 << c) + 1;
                if (heap_top_words + span > HEAP_WORDS)
                begin
                    r.status = STATUS_EXHAUSTED;
                end
                else
                begin
                    a = heap_top_words[ADDR_BITS-1:0];
                    r.block_addr = a;
                    heap_top_words += span;
                    first_word_of[a] = WORD_BITS'(w.tri_count);
                    carved_blocks.push_back(a);
                end
            end
        end
        else
        begin
            // free: the stored word is read as a count, even if it holds a link
            a = w.free_addr;
            stored = first_word_of.exists(a) ? longint'(first_word_of[a]) : 0;
            c = class_of(stored);
            if (c >= NUM_CLASSES)
            begin
                r.status = STATUS_TOO_LARGE;
            end
            else
            begin
                r.block_addr = a;
                first_word_of[a] = list_head[c];
                list_head[c] = {1'b1, a};
            end
        end
        r.size_class = SCLASS_BITS'(c);
        return r;
    endfunction

    // present one word, hold it until taken, then predict its result
    task automatic send_req(input req_t w, output rsp_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        r = allocate_or_free(w);
        expected_blocks.push_back(r);
    endtask

    task automatic alloc_block(input logic [COUNT_BITS-1:0] count, output rsp_t r);
        req_t w;
        w.cmd = CMD_ALLOC;
        w.tri_count = count;
        // address field is don't-care on an allocate, keep it moving
        w.free_addr = FADDR_BITS'($urandom);
        send_req(w, r);
    endtask

    task automatic free_block(input logic [ADDR_BITS-1:0] addr, output rsp_t r);
        req_t w;
        w.cmd = CMD_FREE;
        w.tri_count = COUNT_BITS'($urandom);
        w.free_addr = addr;
        send_req(w, r);
    endtask

    // sender holds off until every owed result has come back
    task automatic wait_all_results();
        if (expected_blocks.size() != 0)
        begin
            req_valid <= 1'b0;
            while (expected_blocks.size() != 0)
            begin
                @(posedge clk);
            end
        end
    endtask

    // result side: random stalls on ready, compare every taken word
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none actual %h", $time, rsp);
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (rsp.block_addr !== want.block_addr)
                begin
                    mismatch_count++;
                    $display("%0t: block_addr expected %0d actual %0d",
                             $time, want.block_addr, rsp.block_addr);
                end
                if (rsp.size_class !== want.size_class)
                begin
                    mismatch_count++;
                    $display("%0t: size_class expected %0d actual %0d",
                             $time, want.size_class, rsp.size_class);
                end
                if (rsp.status !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                end
            end
        end
        rsp_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // boundary counts, both commands, oversize counts, pops of every kind,
    // and frees of blocks already on a list (the stored link reads as a huge count)
    task automatic test_directed();
        rsp_t                 r;
        logic [ADDR_BITS-1:0] a0;
        logic [ADDR_BITS-1:0] a1;
        logic [ADDR_BITS-1:0] b;
        logic [ADDR_BITS-1:0] c;
        logic [ADDR_BITS-1:0] d;
        logic [ADDR_BITS-1:0] e;
        alloc_block(17'd0, r);
        a0 = r.block_addr;
        alloc_block(17'd1, r);
        a1 = r.block_addr;
        alloc_block(17'd2, r);
        b = r.block_addr;
        alloc_block(17'd3, r);
        c = r.block_addr;
        alloc_block(17'd4, r);
        d = r.block_addr;
        // largest class, then the two oversize counts
        alloc_block(17'd65536, r);
        e = r.block_addr;
        alloc_block(17'd65537, r);
        alloc_block(17'h1FFFF, r);
        // class 0 list: a0, then a1 linked to a0 at address 0
        free_block(a0, r);
        free_block(a1, r);
        free_block(a1, r);
        // class 2 list: c, then d linked to c
        free_block(c, r);
        free_block(d, r);
        free_block(d, r);
        // pops come back in reverse order
        alloc_block(17'd1, r);
        alloc_block(17'd0, r);
        alloc_block(17'd4, r);
        alloc_block(17'd3, r);
        free_block(e, r);
        alloc_block(17'd40000, r);
        free_block(b, r);
        alloc_block(17'd2, r);
        live_blocks = '{a0, a1, b, c, d, e};
    endtask

    // mostly allocate/free pairs on live blocks with random counts, some
    // frees of stale blocks as noise, an occasional full drain
    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        rsp_t                  r;
        int unsigned           roll;
        int unsigned           idx;
        int                    c;
        logic [COUNT_BITS-1:0] count;
        logic [ADDR_BITS-1:0]  a;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) == 0)
                wait_all_results();
            roll = $urandom_range(99);
            if (roll < 42 && live_blocks.size() != 0)
            begin
                idx = $urandom_range(live_blocks.size() - 1);
                a = live_blocks[idx];
                live_blocks.delete(idx);
                free_block(a, r);
            end
            else if (roll < 47 && carved_blocks.size() != 0)
            begin
                // stale or double free of some block that was once carved
                free_block(carved_blocks[$urandom_range(carved_blocks.size() - 1)], r);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 1)
                begin
                    count = COUNT_BITS'($urandom_range(131071, 65537));
                end
                else
                begin
                    if (roll < 3)
                        c = $urandom_range(16, 11);
                    else if (roll < 15)
                        c = $urandom_range(10, 6);
                    else
                        c = $urandom_range(5, 0);
                    if (c == 0)
                        count = COUNT_BITS'($urandom_range(1, 0));
                    else
                        count = COUNT_BITS'($urandom_range(1 << c, (1 << (c - 1)) + 1));
                end
                alloc_block(count, r);
                if (r.status == STATUS_OK)
                    live_blocks.push_back(r.block_addr);
            end
        end
    endtask

    // fill the heap from the largest class down, each class until a carve is refused or its try limit runs out
    task automatic test_heap_exhaustion();
        rsp_t r;
        int   tries;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            tries = 0;
            do
            begin
                alloc_block(COUNT_BITS'(64'd1 << c), r);
                if (r.status == STATUS_OK)
                    live_blocks.push_back(r.block_addr);
                tries++;
            end
            while (r.status != STATUS_EXHAUSTED && tries < ((c == NUM_CLASSES - 1) ? 40 : 12));
        end
    endtask

    // guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_ready <= 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++)
            list_head[i] = '0;
        heap_top_words = 0;
        mismatch_count = 0;
        send_idle_pct = 22;
        recv_idle_pct = 82;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(350, 22, 82);
        test_random_traffic(350, 82, 22);
        test_heap_exhaustion();
        // full heap: pops still work, carves mostly refused
        wait_all_results();
        test_random_traffic(350, 0, 0);

        wait_all_results();
        req_valid <= 1'b0;
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
